@@ hw/rtl/scws_pkg.sv @@
// Shared types, constants and register map for the source comment and whitespace stripper.
`default_nettype none

package scws_pkg;

	// Default lookahead depth, also the longest delimiter that can ever be matched
	localparam int DEF_MAX_DELIM_LEN = 4;
	// Delimiter words carry at most four bytes
	localparam int WORD_BYTES        = 4;
	localparam int LEN_W             = 3;
	localparam int SKIP_W            = 2;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WORD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LEN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_WORD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_LEN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_WORD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LEN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE    = 3'd6;

	// Character codes
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [2:0] {
		MODE_CODE  = 3'd0,
		MODE_LINE  = 3'd1,
		MODE_BLOCK = 3'd2,
		MODE_SQ    = 3'd3,
		MODE_DQ    = 3'd4
	} mode_t;

	// Lexer state carried from byte to byte
	typedef struct packed {
		mode_t             mode;
		logic [SKIP_W-1:0] skip;
		logic [7:0]        prev;
		logic              prev_valid;
	} st_t;

	localparam st_t ST_RESET = '{mode: MODE_CODE, skip: '0, prev: '0, prev_valid: 1'b0};

	typedef struct packed {
		logic [CFG_DATA_W-1:0] line_word;
		logic [LEN_W-1:0]      line_len;
		logic [CFG_DATA_W-1:0] open_word;
		logic [LEN_W-1:0]      open_len;
		logic [CFG_DATA_W-1:0] close_word;
		logic [LEN_W-1:0]      close_len;
		logic                  squeeze;
	} cfg_t;

	// One result on the output stream
	typedef struct packed {
		logic       last;
		logic       valid;
		logic [7:0] data;
	} out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/source_comment_whitespace_stripper_top.sv @@
// Top level of the source comment and whitespace stripper.
//
//  channel   direction  payload                                      transfer when
//  s_axis    in         tdata[7:0] in_byte, tlast in_last            tvalid & tready
//  m_axis    out        tdata[7:0] out_byte, tuser out_valid,        tvalid & tready
//                       tlast out_last
//  cfg       in         cfg_index register, cfg_data value           cfg_valid & cfg_ready
//
// One byte is taken per cycle while s_axis_tready is high; the lexer examines the
// byte that has a full window of MAX_DELIM_LEN bytes in view and writes its result
// into a two-deep output queue. A byte with tlast starts a drain with s_axis_tready
// low; it examines the n held bytes (n <= MAX_DELIM_LEN), then queues the final result.
// s_axis_tready drops only while draining or while the output queue is full.
// Reset clears all control state at once; the window data needs no clearing.
`default_nettype none

module source_comment_whitespace_stripper_top #(
	parameter  int MAX_DELIM_LEN = scws_pkg::DEF_MAX_DELIM_LEN,
	localparam int CW            = $clog2(MAX_DELIM_LEN + 1)
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [7:0]                       s_axis_tdata,   // [7:0] in_byte
	input  wire                              s_axis_tlast,   // in_last
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [7:0]                       m_axis_tdata,   // [7:0] out_byte
	output logic                             m_axis_tuser,   // out_valid
	output logic                             m_axis_tlast,   // out_last
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [scws_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [scws_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import scws_pkg::*;

	cfg_t       cfg;
	logic [7:0] win_q [MAX_DELIM_LEN];
	logic [CW-1:0] cnt_q;
	logic       drain_q;
	st_t        st_q;
	logic       pend_valid_q;
	logic [7:0] pend_q;

	logic [7:0]    view_acc [MAX_DELIM_LEN];
	logic [7:0]    ex_view  [MAX_DELIM_LEN];
	logic [CW-1:0] n_acc;
	logic [CW-1:0] ex_n;
	st_t           ex_st;
	logic          ex_keep;
	logic [7:0]    ex_byte;

	logic       acc;
	logic       full;
	logic       step_norm;
	logic       step_drain;
	logic       flush;
	logic       push;
	out_item_t  push_item;
	out_item_t  out_item;

	assign cfg_ready = 1'b1;

	scws_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake and step decode
	assign s_axis_tready = !drain_q && !full;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign n_acc         = cnt_q + CW'(1);
	assign step_norm     = acc && !s_axis_tlast && (n_acc == CW'(MAX_DELIM_LEN));
	assign step_drain    = drain_q && !full && (cnt_q != '0);
	assign flush         = drain_q && !full && (cnt_q == '0);

	// View: held bytes with the incoming byte appended
	always_comb begin
		for (int i = 0; i < MAX_DELIM_LEN; i++) begin
			view_acc[i] = (CW'(i) == cnt_q) ? s_axis_tdata : win_q[i];
			ex_view[i]  = drain_q ? win_q[i] : view_acc[i];
		end
	end

	assign ex_n = drain_q ? cnt_q : n_acc;

	scws_examine #(
		.MAX_DELIM_LEN (MAX_DELIM_LEN)
	) u_examine (
		.view      (ex_view),
		.n         (ex_n),
		.st        (st_q),
		.cfg       (cfg),
		.st_next   (ex_st),
		.keep      (ex_keep),
		.kept_byte (ex_byte)
	);

	// Results into the queue; during a drain the newest kept byte waits so the
	// final one can carry tlast
	always_comb begin
		push      = 1'b0;
		push_item = '0;
		if (step_norm && ex_keep) begin
			push      = 1'b1;
			push_item = '{last: 1'b0, valid: 1'b1, data: ex_byte};
		end
		if (step_drain && ex_keep && pend_valid_q) begin
			push      = 1'b1;
			push_item = '{last: 1'b0, valid: 1'b1, data: pend_q};
		end
		if (flush) begin
			push      = 1'b1;
			push_item = '{last: 1'b1, valid: pend_valid_q,
				data: (pend_valid_q ? pend_q : 8'h00)};
		end
	end

	scws_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	assign m_axis_tdata = out_item.data;
	assign m_axis_tuser = out_item.valid;
	assign m_axis_tlast = out_item.last;

	// Lexer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			drain_q      <= 1'b0;
			st_q         <= ST_RESET;
			pend_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				if (s_axis_tlast) begin
					cnt_q        <= n_acc;
					drain_q      <= 1'b1;
					pend_valid_q <= 1'b0;
				end else if (step_norm) begin
					st_q <= ex_st;
				end else begin
					cnt_q <= n_acc;
				end
			end
			if (step_drain) begin
				st_q  <= ex_st;
				cnt_q <= cnt_q - CW'(1);
				if (ex_keep) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (flush) begin
				drain_q      <= 1'b0;
				st_q         <= ST_RESET;
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Window and held byte
	always_ff @(posedge clk) begin
		if (acc) begin
			if (step_norm) begin
				for (int i = 0; i < MAX_DELIM_LEN - 1; i++) begin
					win_q[i] <= view_acc[i+1];
				end
			end else begin
				for (int i = 0; i < MAX_DELIM_LEN; i++) begin
					win_q[i] <= view_acc[i];
				end
			end
		end
		if (step_drain) begin
			for (int i = 0; i < MAX_DELIM_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			if (ex_keep) begin
				pend_q <= ex_byte;
			end
		end
	end

	// Checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("result pushed into a full queue");

	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!drain_q |-> (cnt_q < CW'(MAX_DELIM_LEN)))
		else $error("window holds a full view outside a drain");

	a_fresh_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(drain_q) |-> ((st_q.mode == MODE_CODE) && !st_q.prev_valid
			&& (cnt_q == '0) && !pend_valid_q))
		else $error("lexer state not cleared after end of text");

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
		else $error("bare end marker without tlast");

endmodule

`default_nettype wire

@@ hw/rtl/scws_cfg_regs.sv @@
// Configuration register file: decodes writes into the delimiter and squeeze settings.
`default_nettype none

module scws_cfg_regs (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               wr_en,
	input  wire  [scws_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire  [scws_pkg::CFG_DATA_W-1:0]   wr_data,
	output scws_pkg::cfg_t                    cfg
);
	import scws_pkg::*;

	cfg_t cfg_q;

	assign cfg = cfg_q;

	// Register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_LINE_WORD:  cfg_q.line_word  <= wr_data;
				REG_LINE_LEN:   cfg_q.line_len   <= wr_data[LEN_W-1:0];
				REG_OPEN_WORD:  cfg_q.open_word  <= wr_data;
				REG_OPEN_LEN:   cfg_q.open_len   <= wr_data[LEN_W-1:0];
				REG_CLOSE_WORD: cfg_q.close_word <= wr_data;
				REG_CLOSE_LEN:  cfg_q.close_len  <= wr_data[LEN_W-1:0];
				REG_SQUEEZE:    cfg_q.squeeze    <= wr_data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/scws_examine.sv @@
// Examines the head byte of the lookahead view: delimiter match, mode update, squeeze.
`default_nettype none

module scws_examine #(
	parameter  int MAX_DELIM_LEN = scws_pkg::DEF_MAX_DELIM_LEN,
	localparam int CW            = $clog2(MAX_DELIM_LEN + 1)
) (
	input  wire  [7:0]         view [MAX_DELIM_LEN],
	input  wire  [CW-1:0]      n,
	input  scws_pkg::st_t      st,
	input  scws_pkg::cfg_t     cfg,
	output scws_pkg::st_t      st_next,
	output logic               keep,
	output logic [7:0]         kept_byte
);
	import scws_pkg::*;

	// Bytes of a delimiter that can ever be compared
	localparam int DL   = (MAX_DELIM_LEN < WORD_BYTES) ? MAX_DELIM_LEN : WORD_BYTES;
	localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;

	logic [7:0] nxt;
	logic       has_next;

	// Raw byte after the head, if the view holds one
	generate
		if (MAX_DELIM_LEN > 1) begin : g_next
			assign nxt = view[1];
		end else begin : g_no_next
			assign nxt = '0;
		end
	endgenerate

	assign has_next = (CMPW'(n) > CMPW'(1));

	// Length clipped to the word and to the window
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] e;
		e = (len > LEN_W'(WORD_BYTES)) ? LEN_W'(WORD_BYTES) : len;
		if (CMPW'(e) > CMPW'(MAX_DELIM_LEN)) begin
			e = LEN_W'(MAX_DELIM_LEN);
		end
		return e;
	endfunction

	function automatic logic dmatch(input logic [CFG_DATA_W-1:0] word,
			input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] e;
		logic             ok;
		e  = eff_len(len);
		ok = (e != '0) && (CMPW'(e) <= CMPW'(n));
		for (int k = 0; k < DL; k++) begin
			if ((LEN_W'(k) < e) && (view[k] != word[8*k +: 8])) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	function automatic logic is_white(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
	endfunction

	// Space, tab and operator characters next to which whitespace is redundant
	function automatic logic is_joiner(input logic [7:0] c);
		return c inside {8'h20, 8'h09, 8'h3B, 8'h3D, 8'h3A, 8'h7D, 8'h7B, 8'h28, 8'h29,
			8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h26, 8'h7C, 8'h3F, 8'h2C, 8'h3C, 8'h3E};
	endfunction

	logic       back;
	logic       go_code;
	logic       go_out;
	logic       drop;
	logic [7:0] c;
	logic [7:0] ob;

	assign back = st.prev_valid && (st.prev == CH_BSLASH);
	assign c    = view[0];

	always_comb begin
		st_next   = st;
		keep      = 1'b0;
		kept_byte = c;
		go_code   = 1'b0;
		go_out    = 1'b0;
		drop      = 1'b0;
		ob        = c;

		if (st.skip != '0) begin
			// Rest of a matched delimiter
			st_next.skip = st.skip - SKIP_W'(1);
		end else begin
			case (st.mode)
				MODE_LINE: begin
					if ((c == CH_LF) || (c == CH_CR)) begin
						st_next.mode = MODE_CODE;
						go_code      = 1'b1;
					end
				end
				MODE_BLOCK: begin
					if (dmatch(cfg.close_word, cfg.close_len)) begin
						st_next.skip = SKIP_W'(eff_len(cfg.close_len) - LEN_W'(1));
						st_next.mode = MODE_CODE;
					end
				end
				MODE_DQ: begin
					if ((c == CH_DQUOTE) && !back) begin
						st_next.mode = MODE_CODE;
					end
					go_out = 1'b1;
				end
				MODE_SQ: begin
					if ((c == CH_SQUOTE) && !back) begin
						st_next.mode = MODE_CODE;
					end
					go_out = 1'b1;
				end
				default: begin
					st_next.mode = MODE_CODE;
					go_code      = 1'b1;
				end
			endcase

			// Openers and quotes in code
			if (go_code) begin
				if (dmatch(cfg.line_word, cfg.line_len)) begin
					st_next.mode = MODE_LINE;
					st_next.skip = SKIP_W'(eff_len(cfg.line_len) - LEN_W'(1));
				end else if (dmatch(cfg.open_word, cfg.open_len)) begin
					st_next.mode = MODE_BLOCK;
					st_next.skip = SKIP_W'(eff_len(cfg.open_len) - LEN_W'(1));
				end else begin
					if (c == CH_DQUOTE) begin
						st_next.mode = MODE_DQ;
					end else if (c == CH_SQUOTE) begin
						st_next.mode = MODE_SQ;
					end
					go_out = 1'b1;
				end
			end

			// Whitespace squeeze and emit
			if (go_out) begin
				if (cfg.squeeze && (st_next.mode == MODE_CODE)) begin
					if ((c == CH_LF) || (c == CH_CR)) begin
						ob = CH_SPACE;
					end
					if (is_white(ob)) begin
						if (st.prev_valid && is_joiner(st.prev)) begin
							drop = 1'b1;
						end
						if (has_next && is_joiner(nxt)) begin
							drop = 1'b1;
						end
					end
				end
				if (!drop) begin
					keep               = 1'b1;
					kept_byte          = ob;
					st_next.prev       = ob;
					st_next.prev_valid = 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/scws_out_fifo.sv @@
// Two-entry result queue between the lexer and the output stream.
`default_nettype none

module scws_out_fifo (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  scws_pkg::out_item_t   push_item,
	output logic                  full,
	output logic                  out_valid,
	input  wire                   out_ready,
	output scws_pkg::out_item_t   out_item
);
	import scws_pkg::*;

	out_item_t  item_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_item  = item_q[rd_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire
